>>> rtl/cwcr_pkg.sv
// Shared types and constants of the circle wall collision resolver.
// Holds the wall table, the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package cwcr_pkg;

    localparam int POS_W      = 16;               // Q12.4 port positions
    localparam int RAD_W      = 12;               // Q8.4 radius
    localparam int ACC_W      = 20;               // widened centre during the pass
    localparam int DIFF_W     = 21;               // offset to nearest point
    localparam int SQ_W       = 42;               // squared distance
    localparam int MAG_W      = 21;               // distance
    localparam int PROD_W     = 34;               // offset times overlap
    localparam int REM_W      = 35;               // divider remainder
    localparam int QUO_W      = 13;               // rounded push
    localparam int SQRT_STEPS = 21;
    localparam int DIV_STEPS  = 13;
    localparam int STEP_W     = 5;
    localparam int ROM_WALLS  = 6;
    localparam int WALL_W     = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER_LEFT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER_RIGHT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER_TOP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER_BOTTOM = 3'd4;

    localparam logic [RAD_W-1:0] RADIUS_RST        = 12'd800;
    localparam logic [POS_W-1:0] BORDER_LEFT_RST   = 16'd0;
    localparam logic [POS_W-1:0] BORDER_RIGHT_RST  = 16'd30720;
    localparam logic [POS_W-1:0] BORDER_TOP_RST    = 16'd0;
    localparam logic [POS_W-1:0] BORDER_BOTTOM_RST = 16'd17280;

    typedef struct packed {
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] y0;
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
    } wall_t;

    // left, top, right, bottom in Q12.4
    function automatic wall_t wall_rom(input logic [WALL_W-1:0] idx);
        wall_t w;
        case (idx)
            3'd0:    w = '{16'sd4000,  16'sd3200,  16'sd4800,  16'sd12800};
            3'd1:    w = '{16'sd25920, 16'sd3200,  16'sd26720, 16'sd12800};
            3'd2:    w = '{16'sd9600,  16'sd0,     16'sd14400, 16'sd4800};
            3'd3:    w = '{16'sd12800, 16'sd12480, 16'sd17600, 16'sd17280};
            3'd4:    w = '{16'sd12160, 16'sd8480,  16'sd16960, 16'sd9120};
            3'd5:    w = '{16'sd12160, 16'sd9760,  16'sd16960, 16'sd10400};
            default: w = '{16'sd0,     16'sd0,     16'sd0,     16'sd0};
        endcase
        return w;
    endfunction

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLAMP,
        OP_MULT,
        OP_SUM,
        OP_INSIDE,
        OP_SQ_STEP,
        OP_DIV_INIT,
        OP_DIV_PREP,
        OP_DIV_STEP,
        OP_APPLY,
        OP_BORDER,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [WALL_W-1:0] wall;
    } dp_cmd_t;

    typedef struct packed {
        logic d2_zero;
        logic overlap_pos;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_MULT,
        ST_SUM,
        ST_CHECK,
        ST_SQRT,
        ST_OVL,
        ST_DIV_INIT,
        ST_DIV_PREP,
        ST_DIV,
        ST_APPLY,
        ST_BORDER,
        ST_EMIT
    } ctrl_state_t;

endpackage

`default_nettype wire

>>> rtl/cwcr_dp.sv
// Datapath of the collision resolver: config registers, centre, square root,
// two dividers, border clamp and output word register. Uses cwcr_pkg.
`default_nettype none

module cwcr_dp (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [cwcr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [cwcr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire [2*cwcr_pkg::POS_W-1:0]       in_data,
    input  cwcr_pkg::dp_cmd_t                 cmd,
    output cwcr_pkg::dp_stat_t                stat,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [2*cwcr_pkg::POS_W-1:0]      out_data,
    output logic                              out_flag
);
    import cwcr_pkg::*;

    logic        [RAD_W-1:0]  radius_reg;
    logic signed [POS_W-1:0]  bl_reg, br_reg, bt_reg, bb_reg;
    logic signed [ACC_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic                     inside_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic        [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic        [SQ_W-1:0]   n_reg, res_reg, bit_reg, trial;
    logic signed [PROD_W-1:0] prx_reg, pry_reg;
    logic        [REM_W-1:0]  remx_reg, remy_reg, dsh_reg;
    logic        [QUO_W-1:0]  qx_reg, qy_reg;
    logic                     ov_reg;
    logic        [2*POS_W-1:0] od_reg;
    logic                     of_reg;

    wall_t                    w;
    logic signed [ACC_W:0]    cx, cy;
    logic        [MAG_W-1:0]  mag;
    logic signed [MAG_W:0]    ovl;
    logic        [PROD_W-1:0] ax, ay;
    logic signed [ACC_W:0]    r_ext;
    logic signed [ACC_W:0]    fx, fy;
    logic signed [POS_W-1:0]  sx, sy;

    function automatic logic signed [ACC_W:0] border_fix(
        input logic signed [ACC_W:0] p,
        input logic signed [ACC_W:0] r,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi);
        logic signed [ACC_W:0] lo_e, hi_e, res;
        lo_e = {{(ACC_W+1-POS_W){lo[POS_W-1]}}, lo};
        hi_e = {{(ACC_W+1-POS_W){hi[POS_W-1]}}, hi};
        if (p - r < lo_e)
            res = lo_e + r;
        else if (p + r > hi_e)
            res = hi_e - r;
        else
            res = p;
        return res;
    endfunction

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [ACC_W:0] v);
        logic signed [POS_W-1:0] res;
        if (v > (ACC_W+1)'(32767))
            res = 16'sh7FFF;
        else if (v < -(ACC_W+1)'(32768))
            res = 16'sh8000;
        else
            res = v[POS_W-1:0];
        return res;
    endfunction

    function automatic logic signed [ACC_W:0] clampw(
        input logic signed [ACC_W-1:0] p,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi);
        logic signed [ACC_W:0] pe, lo_e, hi_e, res;
        pe   = {p[ACC_W-1], p};
        lo_e = {{(ACC_W+1-POS_W){lo[POS_W-1]}}, lo};
        hi_e = {{(ACC_W+1-POS_W){hi[POS_W-1]}}, hi};
        if (pe < lo_e)
            res = lo_e;
        else if (pe > hi_e)
            res = hi_e;
        else
            res = pe;
        return res - pe;
    endfunction

    always_comb
    begin
        w     = wall_rom(cmd.wall);
        cx    = clampw(px_reg, w.x0, w.x1);
        cy    = clampw(py_reg, w.y0, w.y1);
        mag   = res_reg[MAG_W-1:0];
        ovl   = $signed({2'b00, radius_reg}) - $signed({1'b0, mag});
        ax    = prx_reg[PROD_W-1] ? PROD_W'(-prx_reg) : PROD_W'(prx_reg);
        ay    = pry_reg[PROD_W-1] ? PROD_W'(-pry_reg) : PROD_W'(pry_reg);
        trial = res_reg + bit_reg;
        r_ext = $signed({{(ACC_W+1-RAD_W){1'b0}}, radius_reg});
        fx    = border_fix({px_reg[ACC_W-1], px_reg}, r_ext, bl_reg, br_reg);
        fy    = border_fix({py_reg[ACC_W-1], py_reg}, r_ext, bt_reg, bb_reg);
        sx    = sat16({px_reg[ACC_W-1], px_reg});
        sy    = sat16({py_reg[ACC_W-1], py_reg});
        px_next = prx_reg[PROD_W-1] ? px_reg + ACC_W'(qx_reg) : px_reg - ACC_W'(qx_reg);
        py_next = pry_reg[PROD_W-1] ? py_reg + ACC_W'(qy_reg) : py_reg - ACC_W'(qy_reg);
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            bl_reg     <= BORDER_LEFT_RST;
            br_reg     <= BORDER_RIGHT_RST;
            bt_reg     <= BORDER_TOP_RST;
            bb_reg     <= BORDER_BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RADIUS:        radius_reg <= cfg_data[RAD_W-1:0];
                REG_BORDER_LEFT:   bl_reg     <= cfg_data;
                REG_BORDER_RIGHT:  br_reg     <= cfg_data;
                REG_BORDER_TOP:    bt_reg     <= cfg_data;
                REG_BORDER_BOTTOM: bb_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.op == OP_EMIT)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                px_reg     <= ACC_W'($signed(in_data[POS_W-1:0]));
                py_reg     <= ACC_W'($signed(in_data[2*POS_W-1:POS_W]));
                inside_reg <= 1'b0;
            end
            OP_CLAMP:
            begin
                dx_reg <= cx;
                dy_reg <= cy;
            end
            OP_MULT:
            begin
                sqx_reg <= SQ_W'(dx_reg * dx_reg);
                sqy_reg <= SQ_W'(dy_reg * dy_reg);
            end
            OP_SUM:
            begin
                n_reg   <= sqx_reg + sqy_reg;
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
            end
            OP_INSIDE:
                inside_reg <= 1'b1;
            OP_SQ_STEP:
            begin
                if (n_reg >= trial)
                begin
                    n_reg   <= n_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                prx_reg <= PROD_W'(dx_reg * $signed({1'b0, ovl[RAD_W-1:0]}));
                pry_reg <= PROD_W'(dy_reg * $signed({1'b0, ovl[RAD_W-1:0]}));
            end
            OP_DIV_PREP:
            begin
                remx_reg <= {ax[REM_W-3:0], 1'b0} + REM_W'(mag);
                remy_reg <= {ay[REM_W-3:0], 1'b0} + REM_W'(mag);
                dsh_reg  <= REM_W'({mag, 1'b0}) << (DIV_STEPS - 1);
                qx_reg   <= '0;
                qy_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                if (remx_reg >= dsh_reg)
                begin
                    remx_reg <= remx_reg - dsh_reg;
                    qx_reg   <= {qx_reg[QUO_W-2:0], 1'b1};
                end
                else
                    qx_reg <= {qx_reg[QUO_W-2:0], 1'b0};
                if (remy_reg >= dsh_reg)
                begin
                    remy_reg <= remy_reg - dsh_reg;
                    qy_reg   <= {qy_reg[QUO_W-2:0], 1'b1};
                end
                else
                    qy_reg <= {qy_reg[QUO_W-2:0], 1'b0};
                dsh_reg <= dsh_reg >> 1;
            end
            OP_APPLY:
            begin
                px_reg <= px_next;
                py_reg <= py_next;
            end
            OP_BORDER:
            begin
                px_reg <= fx[ACC_W-1:0];
                py_reg <= fy[ACC_W-1:0];
            end
            OP_EMIT:
            begin
                od_reg <= {sy, sx};
                of_reg <= inside_reg;
            end
            default: ;
        endcase
    end

    assign stat.d2_zero     = (n_reg == '0);
    assign stat.overlap_pos = (ovl > 0);
    assign stat.out_free    = !ov_reg || out_ready;
    assign out_valid        = ov_reg;
    assign out_data         = od_reg;
    assign out_flag         = of_reg;

endmodule

`default_nettype wire

>>> rtl/cwcr_ctrl.sv
// Controller of the collision resolver: walks the walls and sequences the
// datapath steps. Uses cwcr_pkg.
`default_nettype none

module cwcr_ctrl #(
    parameter int WALL_COUNT = 6
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  cwcr_pkg::dp_stat_t  stat,
    output cwcr_pkg::dp_cmd_t   cmd
);
    import cwcr_pkg::*;

    localparam int WALLS_USED = (WALL_COUNT < ROM_WALLS) ? WALL_COUNT : ROM_WALLS;
    localparam logic [WALL_W-1:0] LAST_WALL = WALL_W'(WALLS_USED - 1);

    ctrl_state_t         state_reg, state_next;
    logic [WALL_W-1:0]   wall_reg, wall_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                last_wall;

    assign last_wall = (wall_reg == LAST_WALL);

    always_comb
    begin
        state_next = state_reg;
        wall_next  = wall_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = ST_CLAMP;
                    wall_next  = '0;
                end
            ST_CLAMP: state_next = ST_MULT;
            ST_MULT:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_CHECK;
            ST_CHECK:
            begin
                state_next = stat.d2_zero ? ST_BORDER : ST_SQRT;
                step_next  = '0;
            end
            ST_SQRT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    state_next = ST_OVL;
            end
            ST_OVL:
                if (stat.overlap_pos)
                    state_next = ST_DIV_INIT;
                else if (last_wall)
                    state_next = ST_BORDER;
                else
                begin
                    state_next = ST_CLAMP;
                    wall_next  = wall_reg + 1'b1;
                end
            ST_DIV_INIT: state_next = ST_DIV_PREP;
            ST_DIV_PREP:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_APPLY;
            end
            ST_APPLY:
                if (last_wall)
                    state_next = ST_BORDER;
                else
                begin
                    state_next = ST_CLAMP;
                    wall_next  = wall_reg + 1'b1;
                end
            ST_BORDER: state_next = ST_EMIT;
            ST_EMIT:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.wall = wall_reg;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_CLAMP:    cmd.op = OP_CLAMP;
            ST_MULT:     cmd.op = OP_MULT;
            ST_SUM:      cmd.op = OP_SUM;
            ST_CHECK:    cmd.op = stat.d2_zero ? OP_INSIDE : OP_NONE;
            ST_SQRT:     cmd.op = OP_SQ_STEP;
            ST_DIV_INIT: cmd.op = OP_DIV_INIT;
            ST_DIV_PREP: cmd.op = OP_DIV_PREP;
            ST_DIV:      cmd.op = OP_DIV_STEP;
            ST_APPLY:    cmd.op = OP_APPLY;
            ST_BORDER:   cmd.op = OP_BORDER;
            ST_EMIT:     cmd.op = stat.out_free ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wall_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wall_reg  <= wall_next;
            step_reg  <= step_next;
        end
    end

    a_wall_range: assert property (@(posedge clk) disable iff (!rst_n)
        wall_reg <= LAST_WALL)
        else $error("wall index beyond the walls in use");

    a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT |-> step_reg < STEP_W'(SQRT_STEPS))
        else $error("square root ran too many steps");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> step_reg < STEP_W'(DIV_STEPS))
        else $error("divider ran too many steps");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |=> state_reg == ST_IDLE)
        else $error("result emitted without return to idle");

endmodule

`default_nettype wire

>>> rtl/circle_wall_collision_resolve_unit.sv
// Top level of the circle wall collision resolver.
// Instantiates cwcr_ctrl and cwcr_dp; uses cwcr_pkg.
`default_nettype none

// Pushes a circle centre (Q12.4) out of a fixed table of six wall rectangles
// in table order, then clamps it to the map border inset by the radius and
// saturates it to 16 bits. One input word gives one output word. Every wall
// the centre does not lie on goes through clamp, square, sum, check, a 21
// step one bit per cycle square root and an overlap test; a wall that must
// push the centre out adds a product, divider setup, two 13 step restoring
// dividers run side by side and apply. Each pass also loads the word and
// ends with the border clamp and the emit. A centre lying on a wall ends the
// pass early and sets inside_wall.
// A new input word is taken as soon as the previous result sits in the output
// register, even before it is taken downstream; while that register is still
// full the finished result waits and the input stalls.
// Configuration registers: 0 radius, 1 left, 2 right, 3 top, 4 bottom border;
// write them only while the block is idle.

module circle_wall_collision_resolve_unit #(
    parameter int WALL_COUNT = 6
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [2:0]   cfg_addr,
    input  wire [15:0]  cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,    // [15:0] pos_x, [31:16] pos_y
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [15:0] new_x, [31:16] new_y
    output logic        m_tuser     // [0] inside_wall
);
    import cwcr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence the wall pass
    cwcr_ctrl #(
        .WALL_COUNT (WALL_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold config, centre, arithmetic units and the output word
    cwcr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_flag  (m_tuser)
    );

endmodule

`default_nettype wire

>>> tb/tb_circle_wall_collision_resolve_unit.sv
// Testbench of circle_wall_collision_resolve_unit: streams circle centres
// through the resolver and checks every resolved word against a local predictor.
// Depends on cwcr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_circle_wall_collision_resolve_unit;
    import cwcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 750;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } centre_t;

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic        on_wall;
    } resolved_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    circle_wall_collision_resolve_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor copy of the registers
    longint    pr_radius;
    longint    pr_left, pr_right, pr_top, pr_bottom;

    centre_t   pending_centres[$];
    resolved_t expected_words[$];

    int        mismatch_count;
    int        words_sent, words_checked, inside_hits;
    int        idle_pct;          // idle chance per side, percent
    int        hold_off_cycles;   // receiver hold-off request
    int        quiet_cycles;

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r;
        r = 0;
        for (int b = 21; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r += longint'(1) << b;
        return r;
    endfunction

    // round(num / den), ties away from zero
    function automatic longint round_div(longint num, longint den);
        longint a, q;
        a = (num < 0) ? -num : num;
        q = (2 * a + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint edge_fix(longint p, longint r, longint lo, longint hi);
        if (p - r < lo) return lo + r;
        if (p + r > hi) return hi - r;
        return p;
    endfunction

    function automatic resolved_t resolve_centre(centre_t c);
        resolved_t res;
        wall_t     w;
        longint    px, py, dx, dy, d2, mag, ovl;
        px = c.x;
        py = c.y;
        res.on_wall = 1'b0;
        for (int i = 0; i < ROM_WALLS; i++) begin
            w  = wall_rom(i[WALL_W-1:0]);
            dx = clamp_to(px, w.x0, w.x1) - px;
            dy = clamp_to(py, w.y0, w.y1) - py;
            d2 = dx * dx + dy * dy;
            if (d2 == 0) begin
                res.on_wall = 1'b1;
                break;
            end
            mag = floor_sqrt(d2);
            ovl = pr_radius - mag;
            if (ovl > 0) begin
                px -= round_div(dx * ovl, mag);
                py -= round_div(dy * ovl, mag);
            end
        end
        px = clamp_to(edge_fix(px, pr_radius, pr_left, pr_right), -32768, 32767);
        py = clamp_to(edge_fix(py, pr_radius, pr_top, pr_bottom), -32768, 32767);
        res.nx = px[15:0];
        res.ny = py[15:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // driver: feed pending centres, idle at random
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            // current word accepted (or none shown); present the next one
            if (pending_centres.size() > 0 && $urandom_range(99) >= idle_pct) begin
                centre_t c;
                c = pending_centres.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {c.y, c.x};
                expected_words = {expected_words, resolve_centre(c)};
                words_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: stall at random, compare accepted words
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want,
                 words_checked);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, 0);
                end else begin
                    resolved_t e;
                    e = expected_words.pop_front();
                    if (m_tdata[15:0] !== e.nx)
                        report_mismatch("new_x", $signed(m_tdata[15:0]), $signed(e.nx));
                    if (m_tdata[31:16] !== e.ny)
                        report_mismatch("new_y", $signed(m_tdata[31:16]), $signed(e.ny));
                    if (m_tuser !== e.on_wall)
                        report_mismatch("inside_wall", m_tuser, e.on_wall);
                    if (e.on_wall) inside_hits++;
                end
                words_checked++;
            end
            // hold off for a long stretch on request, else stall at random
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // watchdog: count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d words outstanding", expected_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_centre(int x, int y);
        centre_t c;
        c.x = x[15:0];
        c.y = y[15:0];
        pending_centres = {pending_centres, c};
    endtask

    // wait until every queued centre is sent and every word is back
    task automatic drain();
        while (pending_centres.size() > 0 || expected_words.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_RADIUS:        pr_radius = val[11:0];
            REG_BORDER_LEFT:   pr_left   = $signed(val);
            REG_BORDER_RIGHT:  pr_right  = $signed(val);
            REG_BORDER_TOP:    pr_top    = $signed(val);
            REG_BORDER_BOTTOM: pr_bottom = $signed(val);
            default: ;
        endcase
    endtask

    // random centre, mostly near the walls so pushes happen
    task automatic push_random_centre();
        wall_t w;
        int    k;
        k = $urandom_range(9);
        if (k < 6) begin
            w = wall_rom(k[WALL_W-1:0]);
            push_centre($urandom_range(w.x1 - w.x0 + 2000) + w.x0 - 1000,
                        $urandom_range(w.y1 - w.y0 + 2000) + w.y0 - 1000);
        end else if (k < 8) begin
            push_centre($urandom_range(32000), $urandom_range(18000));
        end else begin
            push_centre($signed(16'($urandom)), $signed(16'($urandom)));
        end
    endtask

    task automatic random_phase(int n);
        repeat (n) push_random_centre();
        drain();
    endtask

    initial begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_data = '0;
        idle_pct = 22;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        mismatch_count = 0;
        words_sent = 0;
        words_checked = 0;
        inside_hits = 0;
        pr_radius = RADIUS_RST;
        pr_left   = $signed(BORDER_LEFT_RST);
        pr_right  = $signed(BORDER_RIGHT_RST);
        pr_top    = $signed(BORDER_TOP_RST);
        pr_bottom = $signed(BORDER_BOTTOM_RST);
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, on-wall centres, border cases, reset config
        push_centre(-32768, -32768);
        push_centre(32767, 32767);
        push_centre(-32768, 32767);
        push_centre(32767, -32768);
        push_centre(0, 0);
        push_centre(-1, -1);
        push_centre(4400, 8000);     // inside first wall
        push_centre(4000, 3200);     // wall corner
        push_centre(26720, 12800);   // far corner of second wall
        push_centre(14560, 8800);    // inside a later wall
        push_centre(3900, 8000);     // touching from the left
        push_centre(4400, 13000);    // touching from below
        push_centre(3950, 3150);     // diagonal at a corner
        push_centre(12000, 4900);
        push_centre(14500, 9440);    // between two thin walls
        push_centre(15000, 15000);
        push_centre(100, 100);       // border clamp low
        push_centre(30700, 17200);   // border clamp high
        drain();

        // max radius, crossed top/bottom borders (low edge wins)
        write_reg(REG_RADIUS, 16'd4095);
        write_reg(REG_BORDER_LEFT, 16'h8000);
        write_reg(REG_BORDER_RIGHT, 16'h7fff);
        write_reg(REG_BORDER_TOP, 16'd20000);
        write_reg(REG_BORDER_BOTTOM, 16'd100);
        write_reg(3'd7, 16'hffff);   // out-of-range index, ignored
        push_centre(32767, -32768);
        push_centre(-32768, 32767);
        push_centre(4400, 2000);
        push_centre(14000, 11000);
        random_phase(80);

        // zero radius, no idling for a long stretch
        idle_pct = 0;
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_BORDER_LEFT, 16'd0);
        write_reg(REG_BORDER_RIGHT, 16'd0);
        write_reg(REG_BORDER_TOP, 16'h8000);
        write_reg(REG_BORDER_BOTTOM, 16'h7fff);
        random_phase(150);
        idle_pct = 22;

        // receiver holds off while sender keeps offering
        write_reg(REG_RADIUS, 16'd800);
        write_reg(REG_BORDER_LEFT, 16'd0);
        write_reg(REG_BORDER_RIGHT, 16'd30720);
        write_reg(REG_BORDER_TOP, 16'd0);
        write_reg(REG_BORDER_BOTTOM, 16'd17280);
        hold_off_cycles = 2000;
        random_phase(220);

        // random radius and random borders
        write_reg(REG_RADIUS, 16'($urandom_range(4095)));
        write_reg(REG_BORDER_LEFT, 16'($urandom_range(8000)));
        write_reg(REG_BORDER_RIGHT, 16'($urandom_range(32767, 20000)));
        write_reg(REG_BORDER_TOP, 16'($urandom));
        write_reg(REG_BORDER_BOTTOM, 16'($urandom));
        random_phase(300);

        $display("sent %0d centres, checked %0d words, %0d on a wall", words_sent,
                 words_checked, inside_hits);
        $display("covered radius 0/mid/max, crossed and open borders, receiver hold-off");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> files.f
rtl/cwcr_pkg.sv
rtl/cwcr_dp.sv
rtl/cwcr_ctrl.sv
rtl/circle_wall_collision_resolve_unit.sv
tb/tb_circle_wall_collision_resolve_unit.sv
